>>> rtl/gmpc_pkg.sv
`default_nettype none

package gmpc_pkg;

    localparam int MAX_COLS    = 1024;
    localparam int MAX_ROWS    = 1024;
    localparam int COL_W       = $clog2(MAX_COLS);
    localparam int ROW_W       = $clog2(MAX_ROWS);
    localparam int CNT_W       = 11;
    localparam int CELL_W      = 16;
    localparam int COST_W      = 32;
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic REG_ROW_COUNT = 1'b0;
    localparam logic REG_COL_COUNT = 1'b1;

    typedef struct packed {
        logic [CELL_W-1:0] cell_val;
        logic [COL_W-1:0]  col;
        logic              first_row;
        logic              first_col;
        logic              single_col;
        logic              grid_end;
    } gmpc_item_t;

endpackage

`default_nettype wire

>>> rtl/gmpc_if.sv
`default_nettype none

interface gmpc_in_if;
    import gmpc_pkg::*;

    logic              valid;
    logic              ready;
    logic [CELL_W-1:0] cell_value;

    modport source (output valid, output cell_value, input ready);
    modport sink (input valid, input cell_value, output ready);
endinterface

interface gmpc_out_if;
    import gmpc_pkg::*;

    logic              valid;
    logic              ready;
    logic [COST_W-1:0] path_cost;
    logic              cost_saturated;

    modport source (output valid, output path_cost, output cost_saturated, input ready);
    modport sink (input valid, input path_cost, input cost_saturated, output ready);
endinterface

`default_nettype wire

>>> rtl/gmpc_ram.sv
`default_nettype none

module gmpc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/gmpc_front.sv
`default_nettype none

module gmpc_front (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    gmpc_in_if.sink                              cell_in,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [gmpc_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [gmpc_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [gmpc_pkg::APB_DATA_W-1:0] prdata,
    output logic                                 pready,
    output logic                                 cfg_restart,
    input  wire logic                            q_full,
    output logic                                 q_push,
    output gmpc_pkg::gmpc_item_t                 q_item
);
    import gmpc_pkg::*;

    logic [CNT_W-1:0] row_count_reg;
    logic [CNT_W-1:0] col_count_reg;
    logic [COL_W-1:0] col_idx_reg;
    logic [COL_W-1:0] col_idx_next;
    logic [ROW_W-1:0] row_idx_reg;
    logic [ROW_W-1:0] row_idx_next;

    logic [CNT_W-1:0] rows_eff;
    logic [CNT_W-1:0] cols_eff;
    logic [CNT_W-1:0] rows_less;
    logic [CNT_W-1:0] cols_less;
    logic [COL_W-1:0] col_last;
    logic [ROW_W-1:0] row_last;
    logic [COL_W-1:0] col_cur;
    logic [ROW_W-1:0] row_cur;
    logic             is_last_col;
    logic             is_last_row;
    logic             cfg_write;
    logic             in_fire;

    assign pready      = 1'b1;
    assign cfg_write   = psel && penable && pwrite && pready;
    assign cfg_restart = cfg_write;

    always_comb
    begin
        prdata = '0;
        case (paddr[2])
            REG_ROW_COUNT: prdata[CNT_W-1:0] = row_count_reg;
            REG_COL_COUNT: prdata[CNT_W-1:0] = col_count_reg;
            default:       prdata = '0;
        endcase
    end

    // zero acts as one, oversize acts as the maximum
    always_comb
    begin
        if (row_count_reg == '0)
        begin
            rows_eff = CNT_W'(1);
        end
        else if (row_count_reg > CNT_W'(MAX_ROWS))
        begin
            rows_eff = CNT_W'(MAX_ROWS);
        end
        else
        begin
            rows_eff = row_count_reg;
        end
        if (col_count_reg == '0)
        begin
            cols_eff = CNT_W'(1);
        end
        else if (col_count_reg > CNT_W'(MAX_COLS))
        begin
            cols_eff = CNT_W'(MAX_COLS);
        end
        else
        begin
            cols_eff = col_count_reg;
        end
    end

    assign rows_less = rows_eff - CNT_W'(1);
    assign cols_less = cols_eff - CNT_W'(1);
    assign row_last  = rows_less[ROW_W-1:0];
    assign col_last  = cols_less[COL_W-1:0];

    assign col_cur     = (col_idx_reg > col_last) ? col_last : col_idx_reg;
    assign row_cur     = (row_idx_reg > row_last) ? row_last : row_idx_reg;
    assign is_last_col = (col_cur == col_last);
    assign is_last_row = (row_cur == row_last);

    assign cell_in.ready = !q_full;
    assign in_fire       = cell_in.valid && cell_in.ready;
    assign q_push        = in_fire;

    always_comb
    begin
        q_item.cell_val   = cell_in.cell_value;
        q_item.col        = col_cur;
        q_item.first_row  = (row_cur == '0);
        q_item.first_col  = (col_cur == '0);
        q_item.single_col = (col_last == '0);
        q_item.grid_end   = is_last_col && is_last_row;
    end

    always_comb
    begin
        col_idx_next = col_idx_reg;
        row_idx_next = row_idx_reg;
        if (cfg_write)
        begin
            col_idx_next = '0;
            row_idx_next = '0;
        end
        else if (in_fire)
        begin
            if (!is_last_col)
            begin
                col_idx_next = col_cur + COL_W'(1);
                row_idx_next = row_cur;
            end
            else if (!is_last_row)
            begin
                col_idx_next = '0;
                row_idx_next = row_cur + ROW_W'(1);
            end
            else
            begin
                col_idx_next = '0;
                row_idx_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg <= CNT_W'(1);
            col_count_reg <= CNT_W'(1);
            col_idx_reg   <= '0;
            row_idx_reg   <= '0;
        end
        else
        begin
            col_idx_reg <= col_idx_next;
            row_idx_reg <= row_idx_next;
            if (cfg_write)
            begin
                case (paddr[2])
                    REG_ROW_COUNT: row_count_reg <= pwdata[CNT_W-1:0];
                    REG_COL_COUNT: col_count_reg <= pwdata[CNT_W-1:0];
                    default:       row_count_reg <= row_count_reg;
                endcase
            end
        end
    end

`ifndef SYNTHESIS
    a_grid_end_wraps: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && q_item.grid_end && !cfg_write |=> col_idx_reg == '0 && row_idx_reg == '0)
        else $error("position did not wrap after the last cell");

    a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        !cfg_write && !$past(cfg_write) |-> col_idx_reg <= col_last)
        else $error("column index past the last column");
`endif

endmodule

`default_nettype wire

>>> rtl/gmpc_queue.sv
`default_nettype none

module gmpc_queue (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  gmpc_pkg::gmpc_item_t      push_item,
    output logic                      full,
    input  wire logic                 pop,
    output logic                      valid,
    output gmpc_pkg::gmpc_item_t      head
);
    import gmpc_pkg::*;

    gmpc_item_t        entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    assign full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign valid = (count_reg != '0);
    assign head  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : wr_ptr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : rd_ptr_reg + QPTR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full && push |-> pop)
        else $error("push into a full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> valid)
        else $error("pop from an empty queue");
`endif

endmodule

`default_nettype wire

>>> rtl/gmpc_back.sv
`default_nettype none

module gmpc_back (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_restart,
    input  wire logic                 q_valid,
    input  gmpc_pkg::gmpc_item_t      q_head,
    output logic                      q_pop,
    gmpc_out_if.source                cost_out
);
    import gmpc_pkg::*;

    gmpc_item_t        s1_item_reg;
    logic              s1_v_reg;
    logic [COST_W-1:0] prev_cost_reg;
    logic              sat_seen_reg;
    logic              out_v_reg;
    logic [COST_W-1:0] path_cost_reg;
    logic              cost_sat_reg;

    logic [COST_W-1:0] rdata;
    logic [COST_W-1:0] above;
    logic [COST_W-1:0] best;
    logic [COST_W:0]   sum;
    logic [COST_W-1:0] cost;
    logic              sat;
    logic              s1_fire;
    logic              s1_take;

    assign s1_fire = s1_v_reg && (!s1_item_reg.grid_end || !out_v_reg || cost_out.ready);
    assign s1_take = !s1_v_reg || s1_fire;
    assign q_pop   = q_valid && s1_take;

    gmpc_ram #(
        .WIDTH (COST_W),
        .DEPTH (MAX_COLS)
    ) u_row_ram (
        .clk   (clk),
        .we    (s1_fire),
        .waddr (s1_item_reg.col),
        .wdata (cost),
        .re    (q_pop),
        .raddr (q_head.col),
        .rdata (rdata)
    );

    // with one column the entry above was written by the previous beat
    assign above = s1_item_reg.single_col ? prev_cost_reg : rdata;

    always_comb
    begin
        if (s1_item_reg.first_row && s1_item_reg.first_col)
        begin
            best = '0;
        end
        else if (s1_item_reg.first_row)
        begin
            best = prev_cost_reg;
        end
        else if (s1_item_reg.first_col)
        begin
            best = above;
        end
        else
        begin
            best = (above < prev_cost_reg) ? above : prev_cost_reg;
        end
    end

    assign sum  = {1'b0, best} + {{(COST_W + 1 - CELL_W){1'b0}}, s1_item_reg.cell_val};
    assign sat  = sum[COST_W];
    assign cost = sat ? '1 : sum[COST_W-1:0];

    assign cost_out.valid          = out_v_reg;
    assign cost_out.path_cost      = path_cost_reg;
    assign cost_out.cost_saturated = cost_sat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg     <= 1'b0;
            sat_seen_reg <= 1'b0;
            out_v_reg    <= 1'b0;
        end
        else
        begin
            if (s1_take)
            begin
                s1_v_reg <= q_valid;
            end
            if (cfg_restart)
            begin
                sat_seen_reg <= 1'b0;
            end
            else if (s1_fire)
            begin
                sat_seen_reg <= s1_item_reg.grid_end ? 1'b0 : (sat_seen_reg || sat);
            end
            if (s1_fire && s1_item_reg.grid_end)
            begin
                out_v_reg <= 1'b1;
            end
            else if (cost_out.ready)
            begin
                out_v_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            s1_item_reg <= q_head;
        end
        if (s1_fire)
        begin
            prev_cost_reg <= cost;
            if (s1_item_reg.grid_end)
            begin
                path_cost_reg <= cost;
                cost_sat_reg  <= sat_seen_reg || sat;
            end
        end
    end

`ifndef SYNTHESIS
    a_result_follows_end: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && s1_item_reg.grid_end |=> out_v_reg && !sat_seen_reg)
        else $error("grid end did not produce a result");

    a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_v_reg && !cost_out.ready |=> out_v_reg && $stable(path_cost_reg))
        else $error("pending result lost");
`endif

endmodule

`default_nettype wire

>>> rtl/grid_min_path_cost.sv
// grid_min_path_cost: cheapest right/down path sum through a grid of cell costs.
// cells arrive on cell_in (valid/ready) in row-major order, one beat per cell;
// after the last cell of a row_count x col_count grid one beat leaves on
// cost_out with path_cost and cost_saturated, then the next grid starts.
// row_count at byte address 0, col_count at 4 on the apb port; a zero count
// acts as one, counts above 1024 act as 1024. any register write restarts
// the grid in progress; write only while the block is idle.
// throughput: one cell per cycle unless a stalled cost_out fills the queue, set by
// the running-cost loop (one compare and one 32-bit saturating add) and the row
// cost ram (one read, one write). the last cell passes the queue and the ram read,
// then the cost stage, which registers the result beat.
// a stalled cost_out holds its beat; cells keep flowing until the next grid
// end, then the two-entry queue fills and cell_in.ready drops.
// reset clears the indices and sets both counts to 1; the row cost ram is
// not cleared, the first row of every grid writes it before it is read.
`default_nettype none

module grid_min_path_cost (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    gmpc_in_if.sink                              cell_in,
    gmpc_out_if.source                           cost_out,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [gmpc_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [gmpc_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [gmpc_pkg::APB_DATA_W-1:0] prdata,
    output logic                                 pready
);
    import gmpc_pkg::*;

    logic       cfg_restart;
    logic       q_full;
    logic       q_push;
    logic       q_pop;
    logic       q_valid;
    gmpc_item_t q_item;
    gmpc_item_t q_head;

    gmpc_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cell_in     (cell_in),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .cfg_restart (cfg_restart),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_item      (q_item)
    );

    gmpc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_item),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .head      (q_head)
    );

    gmpc_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_restart (cfg_restart),
        .q_valid     (q_valid),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .cost_out    (cost_out)
    );

endmodule

`default_nettype wire

>>> tb/grid_min_path_cost_test.sv
`default_nettype none

module grid_min_path_cost_test;
    import gmpc_pkg::*;

    localparam int SETTLE_CYCLES = 8;
    localparam int STALL_LIMIT   = 4000;
    localparam int PHASE_CELLS   = 80;

    typedef struct packed {
        logic [COST_W-1:0] cost;
        logic              saturated;
    } path_result_t;

    typedef logic [CELL_W-1:0] cell_list_t[$];

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    gmpc_in_if  cell_bus ();
    gmpc_out_if cost_bus ();

    grid_min_path_cost u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cell_in  (cell_bus),
        .cost_out (cost_bus),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // running-cost model of the block
    logic [CNT_W-1:0]  row_count_reg;
    logic [CNT_W-1:0]  col_count_reg;
    logic [COST_W-1:0] running_row [MAX_COLS];
    logic [COST_W-1:0] left_sum;
    int unsigned       col_pos;
    int unsigned       row_pos;
    logic              grid_saturated;
    path_result_t      expected_costs[$];
    path_result_t      head_cost;

    int failures;
    int cells_sent;
    int quiet_cycles;
    int sender_idle_pct;
    int stall_pct;

    initial clk = 1'b0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic int unsigned effective_count(input logic [CNT_W-1:0] count,
                                                    input int unsigned limit);
        if (count == 0)
            return 1;
        if (count > limit)
            return limit;
        return count;
    endfunction

    function automatic int unsigned grid_cells();
        return effective_count(row_count_reg, MAX_ROWS) * effective_count(col_count_reg, MAX_COLS);
    endfunction

    function automatic void restart_grid();
        left_sum       = '0;
        col_pos        = 0;
        row_pos        = 0;
        grid_saturated = 1'b0;
    endfunction

    function automatic void predict_cell(input logic [CELL_W-1:0] cell_val);
        int unsigned       rows;
        int unsigned       cols;
        int unsigned       c;
        int unsigned       r;
        logic [COST_W-1:0] best;
        logic [COST_W:0]   total;
        logic [COST_W-1:0] cost;
        rows = effective_count(row_count_reg, MAX_ROWS);
        cols = effective_count(col_count_reg, MAX_COLS);
        c    = (col_pos >= cols) ? cols - 1 : col_pos;
        r    = (row_pos >= rows) ? rows - 1 : row_pos;
        if (r == 0 && c == 0)
            best = '0;
        else if (r == 0)
            best = left_sum;
        else if (c == 0)
            best = running_row[c];
        else
            best = (running_row[c] < left_sum) ? running_row[c] : left_sum;
        total = {1'b0, best} + {{(COST_W + 1 - CELL_W){1'b0}}, cell_val};
        if (total[COST_W])
        begin
            grid_saturated = 1'b1;
            cost           = '1;
        end
        else
        begin
            cost = total[COST_W-1:0];
        end
        running_row[c] = cost;
        left_sum       = cost;
        if (c != cols - 1)
        begin
            col_pos = c + 1;
            row_pos = r;
        end
        else if (r != rows - 1)
        begin
            col_pos = 0;
            row_pos = r + 1;
        end
        else
        begin
            expected_costs.push_back('{cost: cost, saturated: grid_saturated});
            restart_grid();
        end
    endfunction

    function automatic logic [CELL_W-1:0] random_cell();
        case ($urandom_range(9))
            0, 1, 2: return CELL_W'($urandom_range(3));
            3:       return '0;
            4:       return '1;
            5:       return CELL_W'($urandom_range(65535, 60000));
            default: return CELL_W'($urandom);
        endcase
    endfunction

    function automatic logic [CNT_W-1:0] random_count();
        case ($urandom_range(19))
            0:       return '0;
            1, 2, 3: return CNT_W'($urandom_range(16, 7));
            default: return CNT_W'($urandom_range(6, 1));
        endcase
    endfunction

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && cost_bus.valid && cost_bus.ready)
        begin
            if (expected_costs.size() == 0)
            begin
                $error("unexpected result beat: path_cost %0d cost_saturated %0b",
                       cost_bus.path_cost, cost_bus.cost_saturated);
                failures++;
            end
            else
            begin
                head_cost = expected_costs.pop_front();
                if (cost_bus.path_cost !== head_cost.cost)
                begin
                    $error("path_cost expected %0d actual %0d",
                           head_cost.cost, cost_bus.path_cost);
                    failures++;
                end
                if (cost_bus.cost_saturated !== head_cost.saturated)
                begin
                    $error("cost_saturated expected %0b actual %0b",
                           head_cost.saturated, cost_bus.cost_saturated);
                    failures++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cost_bus.ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (cell_bus.valid && cell_bus.ready) || (cost_bus.valid && cost_bus.ready)
            || (psel && penable))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    task automatic send_cell(input logic [CELL_W-1:0] value);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            cell_bus.valid <= 1'b0;
            @(posedge clk);
        end
        cell_bus.valid      <= 1'b1;
        cell_bus.cell_value <= value;
        @(posedge clk);
        while (!cell_bus.ready)
            @(posedge clk);
        predict_cell(value);
        cells_sent++;
    endtask

    task automatic send_cells(input cell_list_t values);
        foreach (values[i])
            send_cell(values[i]);
    endtask

    task automatic send_random_cells(input int unsigned count);
        repeat (count)
            send_cell(random_cell());
    endtask

    // holds the sender until every expected result is back and the pipe is empty
    task automatic wait_idle();
        cell_bus.valid <= 1'b0;
        while (expected_costs.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic write_count(input logic reg_sel, input logic [CNT_W-1:0] count);
        logic [APB_DATA_W-1:0] data;
        data              = $urandom;
        data[CNT_W-1:0]   = count;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (reg_sel == REG_ROW_COUNT)
            row_count_reg = data[CNT_W-1:0];
        else
            col_count_reg = data[CNT_W-1:0];
        restart_grid();
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic read_count(input logic reg_sel, input logic [CNT_W-1:0] count);
        logic [APB_DATA_W-1:0] want;
        want = {{(APB_DATA_W-CNT_W){1'b0}}, count};
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {reg_sel, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata !== want)
        begin
            $error("prdata expected %0d actual %0d", want, prdata);
            failures++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_grid(input logic [CNT_W-1:0] rows, input logic [CNT_W-1:0] cols);
        wait_idle();
        write_count(REG_ROW_COUNT, rows);
        read_count(REG_ROW_COUNT, rows);
        write_count(REG_COL_COUNT, cols);
        read_count(REG_COL_COUNT, cols);
    endtask

    task automatic test_reset_counts();
        read_count(REG_ROW_COUNT, 1);
        read_count(REG_COL_COUNT, 1);
        send_cells({16'h0000, 16'hFFFF, 16'h0001});
    endtask

    task automatic test_cell_extremes();
        set_grid(2, 3);
        send_cells({16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF});
        set_grid(2, 2);
        send_cells({16'hAAAA, 16'h5555, 16'h5555, 16'hAAAA});
    endtask

    task automatic test_ties_and_zero_path();
        // zero-cost path down the first column and along the last row
        set_grid(3, 3);
        send_cells({16'd0, 16'd9, 16'd9, 16'd0, 16'd9, 16'd9, 16'd0, 16'd0, 16'd0});
        // equal costs above and to the left
        set_grid(2, 2);
        send_cells({16'd5, 16'd3, 16'd3, 16'd1});
    endtask

    task automatic test_restart_on_write();
        set_grid(3, 3);
        send_random_cells(4);
        set_grid(3, 3);
        send_random_cells(9);
        set_grid(4, 2);
        send_random_cells(5);
        wait_idle();
        write_count(REG_COL_COUNT, 3);
        send_random_cells(12);
    endtask

    task automatic test_pause_until_drained();
        set_grid(1, 2);
        repeat (5)
        begin
            send_random_cells(2);
            wait_idle();
        end
    endtask

    task automatic test_count_extremes();
        set_grid(0, 0);
        send_random_cells(3);
        // oversize grids, each left unfinished and restarted by the next write
        set_grid(2047, 1);
        send_random_cells(120);
        set_grid(1, 2047);
        send_random_cells(120);
    endtask

    task automatic test_random_grids(input int idle_pct, input int stall);
        int          target;
        int unsigned total;
        sender_idle_pct = idle_pct;
        stall_pct       = stall;
        target          = cells_sent + PHASE_CELLS;
        while (cells_sent < target)
        begin
            set_grid(random_count(), random_count());
            total = grid_cells();
            if (total > 1 && $urandom_range(9) == 0)
            begin
                // abandoned grid, the next register write restarts it
                send_random_cells($urandom_range(total - 1, 1));
            end
            else
            begin
                repeat ($urandom_range(4, 1))
                begin
                    send_random_cells(total);
                    if ($urandom_range(4) == 0)
                        wait_idle();
                end
            end
        end
        wait_idle();
        sender_idle_pct = 0;
        stall_pct       = 0;
    endtask

    initial
    begin
        rst_n               = 1'b0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;
        cell_bus.valid      = 1'b0;
        cell_bus.cell_value = '0;
        sender_idle_pct     = 0;
        stall_pct           = 0;
        failures            = 0;
        cells_sent          = 0;
        row_count_reg       = 1;
        col_count_reg       = 1;
        foreach (running_row[i])
            running_row[i] = '0;
        restart_grid();

        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_counts();
        test_cell_extremes();
        test_ties_and_zero_path();
        test_restart_on_write();
        test_pause_until_drained();
        test_count_extremes();
        test_random_grids(0, 0);
        test_random_grids(46, 0);
        test_random_grids(0, 46);
        test_random_grids(26, 26);

        wait_idle();
        if (failures == 0 && expected_costs.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

`default_nettype wire
